FILE: hdl/tvfp_pkg.sv
package tvfp_pkg;

	// Delimiters and digit bounds of the tag=value syntax
	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] TAG_MAX = 16'hFFFF;

	// Depths of the decoupling queue and of the result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 2;

	typedef enum logic [1:0] {
		MODE_TAG   = 2'b01,
		MODE_VALUE = 2'b10
	} mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic               field_valid;
		logic [15:0]        tag;
		logic               tag_error;
		logic [11:0]        value_offset;
		logic [11:0]        value_length;
		logic signed [63:0] value_number;
		logic               value_numeric;
		logic [6:0]         field_index;
		logic               message_end;
		logic               message_ok;
		logic [7:0]         field_count;
	} result_t;

	// Classified byte, as handed from the front to the back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       is_digit;
		logic       is_eq;
		logic       is_soh;
		logic       is_minus;
	} cls_t;

	// Result before sign application: value_number holds the magnitude
	typedef struct packed {
		result_t fld;
		logic    negative;
	} raw_t;

endpackage

FILE: hdl/tvfp_fifo.sv
module tvfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hdl/tvfp_front.sv
module tvfp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tvfp_pkg::item_t item,
	output logic           full,
	output logic           q_wr,
	output tvfp_pkg::cls_t  q_wdata,
	input  logic           q_full
);

	import tvfp_pkg::*;

	logic  v_s1;
	cls_t  cls_s1;
	cls_t  cls_d;
	logic  ready;

	always_comb begin
		cls_d.data_byte = item.data_byte;
		cls_d.last      = item.last;
		cls_d.is_digit  = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
		cls_d.is_eq     = (item.data_byte == CH_EQ);
		cls_d.is_soh    = (item.data_byte == CH_SOH);
		cls_d.is_minus  = (item.data_byte == CH_MINUS);
	end

	// Hold the classified word until the queue has room
	assign ready   = !v_s1 || !q_full;
	assign full    = !ready;
	assign q_wr    = v_s1 && !q_full;
	assign q_wdata = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

FILE: hdl/tvfp_back.sv
module tvfp_back #(
	parameter int MAX_FIELD_COUNT = 128,
	parameter int MSG_BYTES       = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tvfp_pkg::cls_t  cur,
	input  logic           q_empty,
	output logic           q_rd,
	output tvfp_pkg::raw_t  res_s1,
	output logic           res_v_s1,
	input  logic           out_ready
);

	import tvfp_pkg::*;

	localparam int PW = $clog2(MSG_BYTES + 1);
	localparam int FW = $clog2(MAX_FIELD_COUNT + 1);
	localparam int CW = (FW + 1 > 9) ? FW + 1 : 9;

	mode_t         mode_q, mode_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0]   tacc_q, tacc_d;
	logic          bad_q, bad_d;
	logic [PW-1:0] vs_q, vs_d;
	logic [63:0]   nacc_q, nacc_d;
	logic          neg_q, neg_d;
	logic          dig_q, dig_d;
	logic [FW-1:0] found_q, found_d, found_e;

	logic          stage_ready;
	logic          take;
	logic          eligible;
	logic          emit;
	logic          emit_soh;
	logic [19:0]   tag_prod;
	logic [63:0]   num_prod;
	logic [PW-1:0] len_pos;
	logic [PW-1:0] len_full;
	logic [CW-1:0] cnt_fld;
	logic [CW-1:0] cnt_end;
	raw_t          res_d;

	assign stage_ready = !res_v_s1 || out_ready;
	assign take        = !q_empty && stage_ready;
	assign q_rd        = take;

	assign tag_prod = 20'({tacc_q, 3'b000}) + 20'({tacc_q, 1'b0}) + 20'(cur.data_byte[3:0]);
	assign num_prod = {nacc_q[60:0], 3'b000} + {nacc_q[62:0], 1'b0}
		+ {56'd0, cur.data_byte} - 64'd48;

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		tacc_d   = tacc_q;
		bad_d    = bad_q;
		vs_d     = vs_q;
		nacc_d   = nacc_q;
		neg_d    = neg_q;
		dig_d    = dig_q;
		found_d  = found_q;
		emit     = 1'b0;
		emit_soh = 1'b0;
		eligible = (pos_q < PW'(MSG_BYTES)) && (found_q < FW'(MAX_FIELD_COUNT));

		if (eligible) begin
			unique case (mode_q)
				MODE_TAG: begin
					if (cur.is_eq) begin
						mode_d = MODE_VALUE;
						vs_d   = pos_q + PW'(1);
						nacc_d = '0;
						neg_d  = 1'b0;
						dig_d  = 1'b1;
					end else if (cur.is_digit && !bad_q) begin
						if (tag_prod > 20'(TAG_MAX)) begin
							bad_d  = 1'b1;
							tacc_d = TAG_MAX;
						end else begin
							tacc_d = tag_prod[15:0];
						end
					end else begin
						bad_d  = 1'b1;
						tacc_d = TAG_MAX;
					end
					pos_d = pos_q + PW'(1);
				end
				MODE_VALUE: begin
					if (cur.is_soh) begin
						emit     = 1'b1;
						emit_soh = 1'b1;
						mode_d   = MODE_TAG;
					end else if ((pos_q == vs_q) && cur.is_minus) begin
						neg_d = 1'b1;
					end else begin
						nacc_d = num_prod;
						if (!cur.is_digit) begin
							dig_d = 1'b0;
						end
					end
					pos_d = pos_q + PW'(1);
				end
				default: begin
				end
			endcase
		end

		// Close an open value on the final byte
		if (cur.last && (mode_d == MODE_VALUE)) begin
			emit = 1'b1;
		end

		found_e  = found_d + FW'(emit);
		len_pos  = emit_soh ? pos_q : pos_d;
		len_full = len_pos - vs_d;
		cnt_fld  = CW'(found_d) + CW'(1);
		cnt_end  = CW'(found_e);

		res_d = '0;
		if (emit) begin
			res_d.fld.field_valid   = 1'b1;
			res_d.fld.tag           = bad_d ? TAG_MAX : tacc_d;
			res_d.fld.tag_error     = bad_d;
			res_d.fld.value_offset  = 12'(vs_d);
			res_d.fld.value_length  = 12'(len_full);
			res_d.fld.value_number  = nacc_d;
			res_d.fld.value_numeric = (len_full != '0) && dig_d
				&& !(neg_d && (len_full == PW'(1)));
			res_d.fld.field_index   = 7'(found_d);
			res_d.fld.field_count   = (cnt_fld > CW'(255)) ? 8'hFF : 8'(cnt_fld);
			res_d.negative          = neg_d;
		end
		if (cur.last) begin
			res_d.fld.message_end = 1'b1;
			res_d.fld.message_ok  = (found_e != '0);
			res_d.fld.field_count = (cnt_end > CW'(255)) ? 8'hFF : 8'(cnt_end);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TAG;
			pos_q    <= '0;
			found_q  <= '0;
			tacc_q   <= '0;
			bad_q    <= 1'b0;
			vs_q     <= '0;
			nacc_q   <= '0;
			neg_q    <= 1'b0;
			dig_q    <= 1'b1;
			res_v_s1 <= 1'b0;
		end else begin
			if (stage_ready) begin
				res_v_s1 <= take && (emit || cur.last);
			end
			if (take) begin
				if (cur.last || emit) begin
					// Drop the field context once it has been reported
					mode_q <= MODE_TAG;
					tacc_q <= '0;
					bad_q  <= 1'b0;
					vs_q   <= '0;
					nacc_q <= '0;
					neg_q  <= 1'b0;
					dig_q  <= 1'b1;
				end else begin
					mode_q <= mode_d;
					tacc_q <= tacc_d;
					bad_q  <= bad_d;
					vs_q   <= vs_d;
					nacc_q <= nacc_d;
					neg_q  <= neg_d;
					dig_q  <= dig_d;
				end
				if (cur.last) begin
					pos_q   <= '0;
					found_q <= '0;
				end else begin
					pos_q   <= pos_d;
					found_q <= found_e;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready) begin
			res_s1 <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_fieldless_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s1 && !res_s1.fld.field_valid |-> res_s1.fld.message_end)
		else $error("result without a field before message end");

	a_found_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= FW'(MAX_FIELD_COUNT))
		else $error("field count beyond limit");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && cur.last |=> (pos_q == '0) && (found_q == '0) && (mode_q == MODE_TAG))
		else $error("state not restarted after final byte");

	a_ok_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s1 && res_s1.fld.message_ok |-> res_s1.fld.field_count != 8'd0)
		else $error("message ok with no fields");

	a_value_start: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_VALUE |-> (vs_q != '0) && (vs_q <= pos_q))
		else $error("value start outside the bytes taken");
`endif

endmodule

FILE: hdl/tag_value_field_parser.sv
// Path: a byte accepted at the ports passes the front stage register, the queue,
//   the back result stage and the result queue before its result shows on the result ports.
// Throughput: one byte per cycle while the queue holds a word and the result queue has
//   room; each stage moves one word per cycle while its consumer has room.
// Reset: arst_n low clears all parse state and both queues at once; no sweep.
module tag_value_field_parser #(
	parameter int MAX_FIELD_COUNT = 128,
	parameter int MSG_BYTES       = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tvfp_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output tvfp_pkg::result_t result
);

	import tvfp_pkg::*;

	// Front to back queue
	logic                 q_wr;
	cls_t                 q_wdata;
	logic                 q_full;
	logic                 q_rd;
	logic [$bits(cls_t)-1:0] q_rdata;
	logic                 q_empty;

	// Back result stage and result queue
	raw_t                 res_s1;
	logic                 res_v_s1;
	logic                 o_full;
	result_t              o_wdata;
	logic [$bits(result_t)-1:0] o_rdata;

	// Front: take a word, classify it, hold it until the queue has room
	tvfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.q_wr    (q_wr),
		.q_wdata (q_wdata),
		.q_full  (q_full)
	);

	// Short queue: lets the front keep taking words while the back stalls
	tvfp_fifo #(
		.WIDTH ($bits(cls_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd_en  (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back: parse state, digit accumulation and field reporting
	tvfp_back #(
		.MAX_FIELD_COUNT (MAX_FIELD_COUNT),
		.MSG_BYTES       (MSG_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cur       (cls_t'(q_rdata)),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.res_s1    (res_s1),
		.res_v_s1  (res_v_s1),
		.out_ready (!o_full)
	);

	// Apply the sign on the way into the result queue, so the back stage
	// carries the magnitude only
	always_comb begin
		o_wdata = res_s1.fld;
		if (res_s1.negative) begin
			o_wdata.value_number = 64'd0 - res_s1.fld.value_number;
		end
	end

	// Result queue: the oldest word sits on the result ports while empty is low
	tvfp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_v_s1),
		.wdata  (o_wdata),
		.full   (o_full),
		.rd_en  (pop),
		.rdata  (o_rdata),
		.empty  (empty)
	);

	assign result = result_t'(o_rdata);

endmodule
